// ----- src/pesm_pkg.sv -----
// ----------------------------------------------------------------------------
// pesm_pkg
// Types and constants shared by the phase error stability monitor modules.
// ----------------------------------------------------------------------------
package pesm_pkg;

   // request kinds
   localparam logic REQ_FEED    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   // configuration register map (word index, byte address = 4 * index)
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [2:0] REG_PEAK_THRESHOLD     = 3'd0;
   localparam logic [2:0] REG_BUCKET_STEP_UP     = 3'd1;
   localparam logic [2:0] REG_BUCKET_STEP_DOWN   = 3'd2;
   localparam logic [2:0] REG_BUCKET_TRIP_LEVEL  = 3'd3;
   localparam logic [2:0] REG_BUCKET_ALARM_CLEAR = 3'd4;
   localparam logic [2:0] REG_MS_ALARM_SET       = 3'd5;
   localparam logic [2:0] REG_MS_ALARM_CLEAR     = 3'd6;
   localparam logic [2:0] REG_MS_LIMIT           = 3'd7;

   // reset values of the configuration registers
   localparam logic [13:0] RST_PEAK_THRESHOLD     = 14'd154;
   localparam logic [7:0]  RST_BUCKET_STEP_UP     = 8'd32;
   localparam logic [7:0]  RST_BUCKET_STEP_DOWN   = 8'd16;
   localparam logic [8:0]  RST_BUCKET_TRIP_LEVEL  = 9'd128;
   localparam logic [8:0]  RST_BUCKET_ALARM_CLEAR = 9'd64;
   localparam logic [15:0] RST_MS_ALARM_SET       = 16'd2304;
   localparam logic [15:0] RST_MS_ALARM_CLEAR     = 16'd1083;
   localparam logic [15:0] RST_MS_LIMIT           = 16'd5929;

   typedef struct packed {
      logic        req_type;
      logic signed [31:0] phase;
   } pesm_req_type;

   typedef struct packed {
      logic        stable;
      logic        peak_ok;
      logic        rms_ok;
      logic [15:0] mean_square;
      logic [8:0]  bucket_level;
   } pesm_rsp_type;

   typedef struct packed {
      logic [13:0] peak_threshold;
      logic [7:0]  bucket_step_up;
      logic [7:0]  bucket_step_down;
      logic [8:0]  bucket_trip_level;
      logic [8:0]  bucket_alarm_clear;
      logic [15:0] ms_alarm_set;
      logic [15:0] ms_alarm_clear;
      logic [15:0] ms_limit;
   } pesm_cfg_type;

   // control from the pipeline to the tracker
   typedef struct packed {
      logic step;
      logic restart;
      logic peak_hit;
   } pesm_step_type;

endpackage

// ----- src/pesm_front.sv -----
// ----------------------------------------------------------------------------
// pesm_front
// Magnitude, peak compare and scaled square of one phase sample.
// ----------------------------------------------------------------------------
module pesm_front #(
   parameter int PHASE_WIDTH = 32,
   parameter int MAG_CLAMP   = 16384,
   localparam int CLAMP_WIDTH = $clog2(MAG_CLAMP + 1),
   localparam int SQ_WIDTH    = 2 * CLAMP_WIDTH - 4
) (
   input  logic signed [31:0]   phase,
   input  logic [13:0]          peak_threshold,
   output logic                 peak_hit,
   output logic [SQ_WIDTH-1:0]  sq_scaled
);

   logic [PHASE_WIDTH-1:0]   mag_raw;
   logic [PHASE_WIDTH-1:0]   mag;
   logic [CLAMP_WIDTH-1:0]   mag_clamped;
   logic [2*CLAMP_WIDTH-1:0] sq_full;

   assign mag_raw = phase[PHASE_WIDTH-1:0];

   // most negative value negates to itself, which reads correctly as unsigned
   assign mag = mag_raw[PHASE_WIDTH-1] ? (~mag_raw + 1'b1) : mag_raw;

   assign peak_hit = mag > PHASE_WIDTH'(peak_threshold);

   assign mag_clamped = (mag > PHASE_WIDTH'(MAG_CLAMP)) ? CLAMP_WIDTH'(MAG_CLAMP)
                                                        : mag[CLAMP_WIDTH-1:0];

   assign sq_full   = (2*CLAMP_WIDTH)'(mag_clamped) * (2*CLAMP_WIDTH)'(mag_clamped);
   assign sq_scaled = sq_full[2*CLAMP_WIDTH-1:4];

endmodule

// ----- src/pesm_track.sv -----
// ----------------------------------------------------------------------------
// pesm_track
// Leaky bucket and running mean square with their hysteresis flags.
// ----------------------------------------------------------------------------
module pesm_track #(
   parameter int SQ_WIDTH = 26,
   localparam int MS_WIDTH = ((SQ_WIDTH > 16) ? SQ_WIDTH : 16) + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pesm_pkg::pesm_cfg_type cfg,
   input  pesm_pkg::pesm_step_type ctl,
   input  logic [SQ_WIDTH-1:0]    sq_scaled,
   output pesm_pkg::pesm_rsp_type rsp
);

   logic [8:0]  bucket_ff,      bucket_in;
   logic        bucket_good_ff, bucket_good_in;
   logic [15:0] mean_sq_ff,     mean_sq_in;
   logic        rms_good_ff,    rms_good_in;

   logic [8:0]          bucket_new;
   logic [15:0]         ms_keep;
   logic [MS_WIDTH-1:0] ms_sum;

   always_comb begin
      bucket_new = bucket_ff;
      if (ctl.peak_hit) begin
         // rise only below the rise limit
         if (!bucket_ff[8]) begin
            bucket_new = bucket_ff + 9'(cfg.bucket_step_up);
         end
      end else if (bucket_ff > 9'(cfg.bucket_step_down)) begin
         bucket_new = bucket_ff - 9'(cfg.bucket_step_down);
      end else begin
         bucket_new = '0;
      end

      ms_keep = mean_sq_ff - (mean_sq_ff >> 4);
      ms_sum  = MS_WIDTH'(ms_keep) + MS_WIDTH'(sq_scaled);

      bucket_in      = bucket_ff;
      bucket_good_in = bucket_good_ff;
      mean_sq_in     = mean_sq_ff;
      rms_good_in    = rms_good_ff;

      if (ctl.step) begin
         if (ctl.restart) begin
            bucket_in      = cfg.bucket_alarm_clear;
            bucket_good_in = 1'b0;
            mean_sq_in     = cfg.ms_alarm_clear;
            rms_good_in    = 1'b0;
         end else begin
            bucket_in = bucket_new;
            if (bucket_new >= cfg.bucket_trip_level) begin
               bucket_good_in = 1'b0;
            end else if (bucket_new < cfg.bucket_alarm_clear) begin
               bucket_good_in = 1'b1;
            end

            mean_sq_in = ms_sum[15:0];
            if (ms_sum > MS_WIDTH'(cfg.ms_limit)) begin
               mean_sq_in  = cfg.ms_limit;
               rms_good_in = 1'b0;
            end else if (ms_sum > MS_WIDTH'(cfg.ms_alarm_set)) begin
               rms_good_in = 1'b0;
            end else if (ms_sum < MS_WIDTH'(cfg.ms_alarm_clear)) begin
               rms_good_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff      <= pesm_pkg::RST_BUCKET_ALARM_CLEAR;
         bucket_good_ff <= 1'b0;
         mean_sq_ff     <= pesm_pkg::RST_MS_ALARM_CLEAR;
         rms_good_ff    <= 1'b0;
      end else begin
         bucket_ff      <= bucket_in;
         bucket_good_ff <= bucket_good_in;
         mean_sq_ff     <= mean_sq_in;
         rms_good_ff    <= rms_good_in;
      end
   end

   // the state registers are the result: they move only when a result is loaded
   assign rsp.stable       = bucket_good_ff & rms_good_ff;
   assign rsp.peak_ok      = bucket_good_ff;
   assign rsp.rms_ok       = rms_good_ff;
   assign rsp.mean_square  = mean_sq_ff;
   assign rsp.bucket_level = bucket_ff;

endmodule

// ----- src/phase_error_stability_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// phase_error_stability_monitor_unit
// Judges phase stability from a peak leaky bucket and a running mean square.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  req      | in        | req_valid/req_stall | req_data  (req_type, phase)
//  rsp      | out       | rsp_valid/rsp_stall | rsp_data  (stable .. bucket_level)
//  csr      | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
//  One item per cycle sustained unless rsp_stall holds a presented result; each
//  item passes the input register, the square register and the state/result
//  register in that order.
//  The 15x15 clamped square and the peak compare sit between the input and square registers.
//  Synchronous reset restores register and tracker reset values.
//  A stalled result holds the tracker; req_stall rises only once all three
//  stages are full.
// ----------------------------------------------------------------------------
module phase_error_stability_monitor_unit #(
   parameter int PHASE_WIDTH = 32,
   parameter int MAG_CLAMP   = 16384
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pesm_pkg::pesm_req_type                req_data,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pesm_pkg::pesm_rsp_type                rsp_data,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pesm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [pesm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [pesm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);

   localparam int CLAMP_WIDTH = $clog2(MAG_CLAMP + 1);
   localparam int SQ_WIDTH    = 2 * CLAMP_WIDTH - 4;

   pesm_pkg::pesm_cfg_type  cfg_ff;
   logic [2:0]              reg_index;

   pesm_pkg::pesm_req_type  s0_data_ff;
   logic                    s0_valid_ff;
   logic                    s1_valid_ff;
   logic                    s1_restart_ff;
   logic                    s1_peak_ff;
   logic [SQ_WIDTH-1:0]     s1_sq_ff;
   logic                    out_valid_ff;

   logic                    front_peak;
   logic [SQ_WIDTH-1:0]     front_sq;
   logic                    adv_out;
   logic                    s1_free;
   logic                    adv_s1;
   logic                    s0_free;
   pesm_pkg::pesm_step_type step_ctl;

   // ------------------------------------------------------------------ csr
   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_threshold     <= pesm_pkg::RST_PEAK_THRESHOLD;
         cfg_ff.bucket_step_up     <= pesm_pkg::RST_BUCKET_STEP_UP;
         cfg_ff.bucket_step_down   <= pesm_pkg::RST_BUCKET_STEP_DOWN;
         cfg_ff.bucket_trip_level  <= pesm_pkg::RST_BUCKET_TRIP_LEVEL;
         cfg_ff.bucket_alarm_clear <= pesm_pkg::RST_BUCKET_ALARM_CLEAR;
         cfg_ff.ms_alarm_set       <= pesm_pkg::RST_MS_ALARM_SET;
         cfg_ff.ms_alarm_clear     <= pesm_pkg::RST_MS_ALARM_CLEAR;
         cfg_ff.ms_limit           <= pesm_pkg::RST_MS_LIMIT;
      end else if (psel && penable && pwrite) begin
         case (reg_index)
            pesm_pkg::REG_PEAK_THRESHOLD:     cfg_ff.peak_threshold     <= pwdata[13:0];
            pesm_pkg::REG_BUCKET_STEP_UP:     cfg_ff.bucket_step_up     <= pwdata[7:0];
            pesm_pkg::REG_BUCKET_STEP_DOWN:   cfg_ff.bucket_step_down   <= pwdata[7:0];
            pesm_pkg::REG_BUCKET_TRIP_LEVEL:  cfg_ff.bucket_trip_level  <= pwdata[8:0];
            pesm_pkg::REG_BUCKET_ALARM_CLEAR: cfg_ff.bucket_alarm_clear <= pwdata[8:0];
            pesm_pkg::REG_MS_ALARM_SET:       cfg_ff.ms_alarm_set       <= pwdata[15:0];
            pesm_pkg::REG_MS_ALARM_CLEAR:     cfg_ff.ms_alarm_clear     <= pwdata[15:0];
            pesm_pkg::REG_MS_LIMIT:           cfg_ff.ms_limit           <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         pesm_pkg::REG_PEAK_THRESHOLD:     prdata = 32'(cfg_ff.peak_threshold);
         pesm_pkg::REG_BUCKET_STEP_UP:     prdata = 32'(cfg_ff.bucket_step_up);
         pesm_pkg::REG_BUCKET_STEP_DOWN:   prdata = 32'(cfg_ff.bucket_step_down);
         pesm_pkg::REG_BUCKET_TRIP_LEVEL:  prdata = 32'(cfg_ff.bucket_trip_level);
         pesm_pkg::REG_BUCKET_ALARM_CLEAR: prdata = 32'(cfg_ff.bucket_alarm_clear);
         pesm_pkg::REG_MS_ALARM_SET:       prdata = 32'(cfg_ff.ms_alarm_set);
         pesm_pkg::REG_MS_ALARM_CLEAR:     prdata = 32'(cfg_ff.ms_alarm_clear);
         pesm_pkg::REG_MS_LIMIT:           prdata = 32'(cfg_ff.ms_limit);
         default:                          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------- pipeline
   assign adv_out   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_free   = !s1_valid_ff || adv_out;
   assign adv_s1    = s0_valid_ff && s1_free;
   assign s0_free   = !s0_valid_ff || adv_s1;
   assign req_stall = !s0_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s0_free) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (adv_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (s0_free && req_valid) begin
         s0_data_ff <= req_data;
      end
      if (adv_s1) begin
         s1_restart_ff <= (s0_data_ff.req_type == pesm_pkg::REQ_RESTART);
         s1_peak_ff    <= front_peak;
         s1_sq_ff      <= front_sq;
      end
   end

   pesm_front #(
      .PHASE_WIDTH (PHASE_WIDTH),
      .MAG_CLAMP   (MAG_CLAMP)
   ) u_front (
      .phase          (s0_data_ff.phase),
      .peak_threshold (cfg_ff.peak_threshold),
      .peak_hit       (front_peak),
      .sq_scaled      (front_sq)
   );

   assign step_ctl.step     = adv_out;
   assign step_ctl.restart  = s1_restart_ff;
   assign step_ctl.peak_hit = s1_peak_ff;

   pesm_track #(
      .SQ_WIDTH (SQ_WIDTH)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ctl       (step_ctl),
      .sq_scaled (s1_sq_ff),
      .rsp       (rsp_data)
   );

   assign rsp_valid = out_valid_ff;

endmodule
